FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Include by bare file name; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also watches reset itself.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pdc_pkg.sv
// Shared types, constants and register codes for the PID drive controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package pdc_pkg;

    localparam int PDC_ENCODER_SPAN = 8191;

    localparam int IN_W    = 16;          // measured, setpoint
    localparam int ERR_W   = 17;          // error, error history
    localparam int D1_W    = 18;          // first difference
    localparam int D2_W    = 19;          // second difference
    localparam int GAIN_W  = 32;          // Q16.16 gains
    localparam int LIM_W   = 15;          // integer limits and deadband
    localparam int FRAC_W  = 16;          // fraction bits of Q16.16
    localparam int PROD_W  = GAIN_W + D2_W;
    localparam int PI_W    = GAIN_W + ERR_W;
    localparam int INT_W   = 48;          // integral accumulator
    localparam int OUT_W   = 32;          // output accumulator, always clamped
    localparam int SUM_W   = 54;          // working width of the accumulate sums
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Mode register codes
    localparam logic [1:0] MODE_SPEED = 2'd0;
    localparam logic [1:0] MODE_ANGLE = 2'd1;
    localparam logic [1:0] MODE_INCR  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE           = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND      = 3'd6;

    // Reset values of the configuration registers
    localparam logic [1:0]              RST_MODE           = MODE_SPEED;
    localparam logic signed [GAIN_W-1:0] RST_GAIN_P        = 32'sd5243;
    localparam logic signed [GAIN_W-1:0] RST_GAIN_I        = 32'sd655;
    localparam logic signed [GAIN_W-1:0] RST_GAIN_D        = 32'sd0;
    localparam logic [LIM_W-1:0]        RST_INTEGRAL_LIMIT = 15'd1000;
    localparam logic [LIM_W-1:0]        RST_OUTPUT_LIMIT   = 15'd1000;
    localparam logic [LIM_W-1:0]        RST_DEAD_BAND      = 15'd0;

    typedef struct packed {
        logic [1:0]               mode;
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic [LIM_W-1:0]         integral_limit;
        logic [LIM_W-1:0]         output_limit;
        logic [LIM_W-1:0]         dead_band;
    } t_cfg;

    // What the accumulator stage does with one item
    typedef enum logic [1:0] {
        OP_POS  = 2'd0,   // positional PID, clamped integral
        OP_INC  = 2'd1,   // incremental PID
        OP_ZERO = 2'd2,   // inside deadband: zero the output
        OP_HOLD = 2'd3    // unused mode: hold both accumulators
    } t_acc_op;

    typedef struct packed {
        t_acc_op                  op;
        logic signed [PROD_W-1:0] pp;   // P product
        logic signed [PI_W-1:0]   pi;   // I product
        logic signed [PROD_W-1:0] pd;   // D product
    } t_prod;

endpackage

FILE: rtl/pid_position_delta_controller.sv
// PID drive controller: an accepted input item passes the input register, then the product
// register, then the accumulator and result register, which shows the result valid.
// Throughput one item per cycle; a stalled output side holds the three stages in place.
// Reset (synchronous, active low) empties the pipeline, clears the error history and
// both accumulators, and loads the configuration registers with their defaults.
// Depends on pdc_pkg, pdc_err_stage and pdc_acc_stage.
`timescale 1ns / 1ps

module pid_position_delta_controller import pdc_pkg::*; #(
    parameter int ENCODER_SPAN = PDC_ENCODER_SPAN
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [2*IN_W-1:0]     s_axis_tdata,   // [15:0] measured, [31:16] setpoint
    // result items
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [IN_W-1:0]       m_axis_tdata,   // [15:0] drive
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    t_prod w_prod;
    logic  w_prod_valid;
    logic  w_prod_ready;
    logic signed [IN_W-1:0] w_drive;

    // Always ready; the sender must write only while the pipeline is idle, unenforced.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode           <= RST_MODE;
            r_cfg.gain_p         <= RST_GAIN_P;
            r_cfg.gain_i         <= RST_GAIN_I;
            r_cfg.gain_d         <= RST_GAIN_D;
            r_cfg.integral_limit <= RST_INTEGRAL_LIMIT;
            r_cfg.output_limit   <= RST_OUTPUT_LIMIT;
            r_cfg.dead_band      <= RST_DEAD_BAND;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MODE:           r_cfg.mode           <= i_cfg_data[1:0];
                CFG_GAIN_P:         r_cfg.gain_p         <= $signed(i_cfg_data);
                CFG_GAIN_I:         r_cfg.gain_i         <= $signed(i_cfg_data);
                CFG_GAIN_D:         r_cfg.gain_d         <= $signed(i_cfg_data);
                CFG_INTEGRAL_LIMIT: r_cfg.integral_limit <= i_cfg_data[LIM_W-1:0];
                CFG_OUTPUT_LIMIT:   r_cfg.output_limit   <= i_cfg_data[LIM_W-1:0];
                CFG_DEAD_BAND:      r_cfg.dead_band      <= i_cfg_data[LIM_W-1:0];
                default:            ; // drop writes to unmapped indexes
            endcase
        end
    end

    // Stage 1 and 2: hold the item, form the error and the gain products.
    pdc_err_stage #(
        .ENCODER_SPAN (ENCODER_SPAN)
    ) u_err (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_measured   ($signed(s_axis_tdata[IN_W-1:0])),
        .i_setpoint   ($signed(s_axis_tdata[2*IN_W-1:IN_W])),
        .o_prod_valid (w_prod_valid),
        .o_prod       (w_prod),
        .i_prod_ready (w_prod_ready)
    );

    // Stage 3: advance the accumulators and register the drive for the output side.
    pdc_acc_stage u_acc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_prod_valid (w_prod_valid),
        .i_prod       (w_prod),
        .o_prod_ready (w_prod_ready),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_drive      (w_drive)
    );

    assign m_axis_tdata = w_drive;

endmodule

FILE: rtl/pdc_err_stage.sv
// Input register, error forming, angle wrap, deadband test and the three gain products.
// Depends on pdc_pkg.
`timescale 1ns / 1ps

module pdc_err_stage import pdc_pkg::*; #(
    parameter int ENCODER_SPAN = PDC_ENCODER_SPAN
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic signed [IN_W-1:0] i_measured,
    input  logic signed [IN_W-1:0] i_setpoint,
    output logic                  o_prod_valid,
    output t_prod                 o_prod,
    input  logic                  i_prod_ready
);

    localparam logic signed [D1_W-1:0] SPAN_S = D1_W'(ENCODER_SPAN);
    localparam logic signed [D1_W-1:0] HALF_S = D1_W'((ENCODER_SPAN + 1) / 2);

    logic                   r_in_valid;
    logic signed [IN_W-1:0] r_measured;
    logic signed [IN_W-1:0] r_setpoint;
    logic signed [ERR_W-1:0] r_err_last;
    logic signed [ERR_W-1:0] r_err_prev;
    logic                   r_prod_valid;
    t_prod                  r_prod;

    logic                    w_load_in;
    logic                    w_advance;
    logic signed [ERR_W-1:0] w_err_raw;
    logic [ERR_W-2:0]        w_err_mag;
    logic                    w_active;
    logic signed [D1_W-1:0]  w_err_ext;
    logic signed [D1_W-1:0]  w_err_wrap;
    logic signed [ERR_W-1:0] w_err;
    logic                    w_pos;
    logic signed [D1_W-1:0]  w_d1;
    logic signed [D2_W-1:0]  w_d2;
    logic signed [D2_W-1:0]  w_op_p;
    logic signed [D2_W-1:0]  w_op_d;
    t_prod                   n_prod;

    assign w_advance  = r_in_valid && (!r_prod_valid || i_prod_ready);
    assign o_in_ready = !r_in_valid || w_advance;
    assign w_load_in  = i_in_valid && o_in_ready;

    always_comb begin
        w_err_raw = ERR_W'(r_setpoint) - ERR_W'(r_measured);
        w_err_mag = w_err_raw[ERR_W-1] ? (ERR_W-1)'(-w_err_raw) : (ERR_W-1)'(w_err_raw);
        w_active  = (w_err_mag > (ERR_W-1)'(i_cfg.dead_band)) || (i_cfg.dead_band == '0);

        // fold the error back into one turn of the encoder
        w_err_ext = D1_W'(w_err_raw);
        if (w_err_ext > HALF_S) begin
            w_err_wrap = w_err_ext - SPAN_S;
        end else if (w_err_ext < -HALF_S) begin
            w_err_wrap = w_err_ext + SPAN_S;
        end else begin
            w_err_wrap = w_err_ext;
        end

        w_err = (i_cfg.mode == MODE_ANGLE && w_active) ? ERR_W'(w_err_wrap) : w_err_raw;
        w_pos = (i_cfg.mode == MODE_SPEED) || (i_cfg.mode == MODE_ANGLE);

        w_d1 = D1_W'(w_err) - D1_W'(r_err_last);
        w_d2 = D2_W'(w_d1) - D2_W'(r_err_last) + D2_W'(r_err_prev);

        w_op_p = w_pos ? D2_W'(w_err) : D2_W'(w_d1);
        w_op_d = w_pos ? D2_W'(w_d1) : w_d2;

        n_prod.pp = PROD_W'(i_cfg.gain_p) * PROD_W'(w_op_p);
        n_prod.pi = PI_W'(i_cfg.gain_i) * PI_W'(w_err);
        n_prod.pd = PROD_W'(i_cfg.gain_d) * PROD_W'(w_op_d);

        if (!w_active) begin
            n_prod.op = OP_ZERO;
        end else begin
            case (i_cfg.mode)
                MODE_SPEED, MODE_ANGLE: n_prod.op = OP_POS;
                MODE_INCR:              n_prod.op = OP_INC;
                default:                n_prod.op = OP_HOLD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_prod_valid <= 1'b0;
            r_err_last   <= '0;
            r_err_prev   <= '0;
        end else begin
            if (w_load_in) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_prod_valid <= 1'b1;
                r_err_prev   <= r_err_last;
                r_err_last   <= w_err;
            end else if (i_prod_ready) begin
                r_prod_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_in) begin
            r_measured <= i_measured;
            r_setpoint <= i_setpoint;
        end
        if (w_advance) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod_valid = r_prod_valid;
    assign o_prod       = r_prod;

endmodule

FILE: rtl/pdc_acc_stage.sv
// Integral and output accumulators, symmetric clamps and the registered drive result.
// Depends on pdc_pkg.
`timescale 1ns / 1ps

module pdc_acc_stage import pdc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_prod_valid,
    input  t_prod                  i_prod,
    output logic                   o_prod_ready,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic signed [IN_W-1:0] o_drive
);

    function automatic logic signed [SUM_W-1:0] clamp_sym(
        input logic signed [SUM_W-1:0] x,
        input logic signed [SUM_W-1:0] lim
    );
        logic signed [SUM_W-1:0] r;
        if (x > lim) begin
            r = lim;
        end else if (x < -lim) begin
            r = -lim;
        end else begin
            r = x;
        end
        return r;
    endfunction

    logic signed [INT_W-1:0] r_int_acc;
    logic signed [OUT_W-1:0] r_out_acc;
    logic                    r_out_valid;
    logic signed [IN_W-1:0]  r_drive;

    logic                    w_take;
    logic signed [SUM_W-1:0] w_ilim;
    logic signed [SUM_W-1:0] w_olim;
    logic signed [SUM_W-1:0] w_int_clamped;
    logic signed [SUM_W-1:0] w_i_term;
    logic signed [SUM_W-1:0] w_base;
    logic signed [SUM_W-1:0] w_out_clamped;
    logic signed [INT_W-1:0] n_int_acc;
    logic signed [OUT_W-1:0] n_out_acc;
    logic signed [IN_W-1:0]  n_drive;

    assign o_prod_ready = !r_out_valid || i_out_ready;
    assign w_take       = i_prod_valid && o_prod_ready;

    always_comb begin
        w_ilim = SUM_W'($signed({1'b0, i_cfg.integral_limit, FRAC_W'(0)}));
        w_olim = SUM_W'($signed({1'b0, i_cfg.output_limit, FRAC_W'(0)}));

        w_int_clamped = clamp_sym(SUM_W'(r_int_acc) + SUM_W'(i_prod.pi), w_ilim);
        w_i_term = (i_prod.op == OP_INC) ? SUM_W'(i_prod.pi) : w_int_clamped;
        w_base   = (i_prod.op == OP_INC) ? SUM_W'(r_out_acc) : '0;
        w_out_clamped = clamp_sym(w_base + SUM_W'(i_prod.pp) + w_i_term + SUM_W'(i_prod.pd),
                                  w_olim);

        case (i_prod.op)
            OP_POS: begin
                n_int_acc = INT_W'(w_int_clamped);
                n_out_acc = OUT_W'(w_out_clamped);
            end
            OP_INC: begin
                n_int_acc = INT_W'(i_prod.pi);
                n_out_acc = OUT_W'(w_out_clamped);
            end
            OP_ZERO: begin
                n_int_acc = r_int_acc;
                n_out_acc = '0;
            end
            default: begin
                n_int_acc = r_int_acc;
                n_out_acc = r_out_acc;
            end
        endcase

        // integer part, truncated toward zero
        if (n_out_acc[OUT_W-1] && (n_out_acc[FRAC_W-1:0] != '0)) begin
            n_drive = n_out_acc[OUT_W-1:FRAC_W] + IN_W'(1);
        end else begin
            n_drive = n_out_acc[OUT_W-1:FRAC_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_int_acc   <= '0;
            r_out_acc   <= '0;
        end else begin
            if (w_take) begin
                r_out_valid <= 1'b1;
                r_int_acc   <= n_int_acc;
                r_out_acc   <= n_out_acc;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_drive <= n_drive;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;

endmodule

FILE: rtl/pdc_checker.sv
// Port-level checks for the PID drive controller, bound onto the top level.
// Depends on pdc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pdc_checker import pdc_pkg::*; (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_s_tready,
    input logic            i_m_tvalid,
    input logic            i_m_tready,
    input logic [IN_W-1:0] i_m_tdata
);

    // a stalled result holds its value
    `ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata), "result changed while stalled")

    // the symmetric clamp never lets the most negative code through
    `ASSERT_IMPLY(a_drive_range, i_clk, i_rst_n, i_m_tvalid, i_m_tdata != {1'b1, (IN_W-1)'(0)}, "drive outside symmetric range")

    // an open output side always leaves room for a new item
    `ASSERT_IMPLY(a_flow_through, i_clk, i_rst_n, i_m_tready, i_s_tready, "input blocked while output drains")

    // reset empties the pipeline
    `ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, i_s_tready && !i_m_tvalid, "pipeline not empty after reset")

endmodule

bind pid_position_delta_controller pdc_checker u_pdc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);
